// ===== rtl/core/xce_pkg.sv =====
// ----------------------------------------------------------------------------
// XML character escaper: shared definitions
// Types, codes and constants used by the front, queue and back of the escaper.
// ----------------------------------------------------------------------------
package xce_pkg;

  // Lookahead buffer for the ampersand reference check
  localparam int LA_DEPTH = 16;
  localparam int LA_CW    = $clog2(LA_DEPTH + 1);
  localparam int LA_IW    = (LA_DEPTH > 2) ? $clog2(LA_DEPTH) : 1;
  localparam int IDX_W    = (LA_CW > 3) ? LA_CW : 3;

  // Job queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Code point limits for decimal references
  localparam logic [20:0] CP_MIN = 21'h10000;
  localparam logic [20:0] CP_MAX = 21'h10FFFF;
  localparam logic [4:0]  DEC_STEPS = 5'd21;

  // Pending state of the byte parser
  typedef enum logic [2:0] {
    M_IDLE      = 3'd0,
    M_PASS      = 3'd1,
    M_HOLD4     = 3'd2,
    M_AMP_REF   = 3'd3,
    M_AMP_BRACE = 3'd4
  } mode_t;

  // Output pieces the back expands
  typedef enum logic [2:0] {
    K_RAW  = 3'd0,
    K_AMP  = 3'd1,
    K_LT   = 3'd2,
    K_GT   = 3'd3,
    K_QUOT = 3'd4,
    K_HEX  = 3'd5,
    K_DEC  = 3'd6
  } kind_t;

  typedef enum logic {
    F_ACCEPT = 1'b0,
    F_ISSUE  = 1'b1
  } fst_t;

  typedef enum logic [1:0] {
    B_LOAD = 2'd0,
    B_CONV = 2'd1,
    B_SEND = 2'd2
  } bst_t;

  // One job: a piece of output text, with step end markers
  typedef struct packed {
    kind_t       kind;
    logic [20:0] data;
    logic        fin;
    logic        last;
  } job_t;

  // Expanded text of one job
  typedef struct packed {
    logic [9:0][7:0] bytes;
    logic [3:0]      len;
  } seq_t;

endpackage

// ===== rtl/core/xce_front.sv =====
// ----------------------------------------------------------------------------
// XML character escaper: front
// Accepts input bytes, tracks UTF-8 and ampersand state, issues output jobs.
// ----------------------------------------------------------------------------
module xce_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          html_method,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          in_attribute,
  input  logic          last_of_string,
  output logic          q_push,
  output xce_pkg::job_t q_job,
  input  logic          q_full
);
  import xce_pkg::*;

  fst_t              fst_r, fst_nxt;
  mode_t             mode_r, mode_nxt;
  logic [LA_CW-1:0]  la_cnt_r, la_cnt_nxt;
  logic [7:0]        la_mem_r [LA_DEPTH];
  logic [7:0]        hold_r [4];
  logic [2:0]        hold_cnt_r, hold_cnt_nxt;
  logic [1:0]        pass_left_r, pass_left_nxt;

  // Step plan
  logic              pre_v_r, pre_v_nxt;
  kind_t             pre_k_r, pre_k_nxt;
  logic [20:0]       pre_d_r, pre_d_nxt;
  logic [LA_CW-1:0]  la_a_r, la_a_nxt;
  logic              byte_v_r, byte_v_nxt;
  kind_t             byte_k_r, byte_k_nxt;
  logic [7:0]        byte_d_r;
  logic              famp_r, famp_nxt;
  logic [LA_CW-1:0]  la_b_r, la_b_nxt;
  logic [2:0]        hrep_r, hrep_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic              last_r;

  logic              accept, do_idle, html_attr, first, fail, hit, in_set;
  logic              la_we, hold_we, plan_any;
  logic [1:0]        hold_wi;
  logic [20:0]       cp;
  logic              pa, pb, ph, pa_n, pb_n, ph_n, rest;
  logic              sel_pre, sel_byte, sel_famp, sel_rep;
  logic [IDX_W-1:0]  idx_inc;
  logic [IDX_W-1:0]  h_end;
  logic [1:0]        h_idx;

  assign accept    = in_valid && in_ready;
  assign html_attr = html_method && in_attribute;
  assign cp        = {hold_r[0][2:0], hold_r[1][5:0], hold_r[2][5:0], data_byte[5:0]};
  assign in_set    = (data_byte >= "0" && data_byte <= "9") ||
                     (data_byte >= "a" && data_byte <= "f") ||
                     (data_byte >= "A" && data_byte <= "F") ||
                     data_byte == "#" || data_byte == ";";
  assign first     = (la_cnt_r == '0);
  assign fail      = (first && data_byte != "#") || !in_set;
  assign hit       = !fail && data_byte == ";" && !first;

  // Classify the byte and plan the step
  always_comb begin
    mode_nxt      = mode_r;
    la_cnt_nxt    = la_cnt_r;
    hold_cnt_nxt  = hold_cnt_r;
    pass_left_nxt = pass_left_r;
    pre_v_nxt     = 1'b0;
    pre_k_nxt     = K_RAW;
    pre_d_nxt     = {13'd0, data_byte};
    la_a_nxt      = '0;
    la_b_nxt      = '0;
    byte_v_nxt    = 1'b0;
    byte_k_nxt    = K_RAW;
    famp_nxt      = 1'b0;
    hrep_nxt      = 3'd0;
    do_idle       = 1'b0;
    la_we         = 1'b0;
    hold_we       = 1'b0;
    hold_wi       = hold_cnt_r[1:0];
    unique case (mode_r)
      M_PASS: begin
        pre_v_nxt     = 1'b1;
        pass_left_nxt = pass_left_r - {1'b0, (pass_left_r != 2'd0)};
        if (pass_left_nxt == 2'd0) mode_nxt = M_IDLE;
      end
      M_HOLD4: begin
        hold_we      = 1'b1;
        hold_cnt_nxt = hold_cnt_r + 3'd1;
        if (hold_cnt_r == 3'd3) begin
          if (cp >= CP_MIN && cp <= CP_MAX) begin
            pre_v_nxt = 1'b1;
            pre_k_nxt = K_DEC;
            pre_d_nxt = cp;
          end else begin
            hrep_nxt = 3'd4;
          end
          hold_cnt_nxt = 3'd0;
          mode_nxt     = M_IDLE;
        end
      end
      M_AMP_BRACE: begin
        pre_v_nxt = 1'b1;
        if (data_byte == "{") pre_d_nxt = {13'd0, 8'h26};
        else pre_k_nxt = K_AMP;
        mode_nxt = M_IDLE;
        do_idle  = 1'b1;
      end
      M_AMP_REF: begin
        if (fail || hit || la_cnt_r >= LA_CW'(LA_DEPTH)) begin
          pre_v_nxt = 1'b1;
          if (hit) pre_d_nxt = {13'd0, 8'h26};
          else pre_k_nxt = K_AMP;
          la_a_nxt   = la_cnt_r;
          la_cnt_nxt = '0;
          mode_nxt   = M_IDLE;
          do_idle    = 1'b1;
        end else begin
          la_we      = 1'b1;
          la_cnt_nxt = la_cnt_r + 1'b1;
        end
      end
      M_IDLE: do_idle = 1'b1;
      default: begin
        mode_nxt = M_IDLE;
        do_idle  = 1'b1;
      end
    endcase

    // Normal handling of a byte with nothing pending
    if (do_idle) begin
      if (data_byte[7:5] == 3'b110 || data_byte[7:4] == 4'b1110) begin
        byte_v_nxt    = 1'b1;
        pass_left_nxt = (data_byte[7:5] == 3'b110) ? 2'd1 : 2'd2;
        mode_nxt      = M_PASS;
      end else if (data_byte[7:3] == 5'b11110) begin
        hold_we      = 1'b1;
        hold_wi      = 2'd0;
        hold_cnt_nxt = 3'd1;
        mode_nxt     = M_HOLD4;
      end else if ((data_byte >= 8'h01 && data_byte <= 8'h1F) ||
                   (data_byte >= 8'h7F && data_byte <= 8'h9F)) begin
        byte_v_nxt = 1'b1;
        if (in_attribute || (data_byte != 8'h0A && data_byte != 8'h09))
          byte_k_nxt = K_HEX;
      end else if (data_byte == "<") begin
        byte_v_nxt = 1'b1;
        if (!html_attr) byte_k_nxt = K_LT;
      end else if (data_byte == ">") begin
        byte_v_nxt = 1'b1;
        byte_k_nxt = K_GT;
      end else if (data_byte == 8'h22) begin
        byte_v_nxt = 1'b1;
        if (in_attribute) byte_k_nxt = K_QUOT;
      end else if (data_byte == "&") begin
        la_cnt_nxt = '0;
        mode_nxt   = html_attr ? M_AMP_BRACE : M_AMP_REF;
      end else begin
        byte_v_nxt = 1'b1;
      end
    end

    // Flush pending state at string end
    if (last_of_string) begin
      case (mode_nxt)
        M_HOLD4:     hrep_nxt = hold_cnt_nxt;
        M_AMP_BRACE: famp_nxt = 1'b1;
        M_AMP_REF: begin
          famp_nxt = 1'b1;
          la_b_nxt = la_cnt_nxt;
        end
        default: ;
      endcase
      mode_nxt      = M_IDLE;
      la_cnt_nxt    = '0;
      hold_cnt_nxt  = 3'd0;
      pass_left_nxt = 2'd0;
    end
  end

  assign plan_any = pre_v_nxt || (la_a_nxt != '0) || byte_v_nxt || famp_nxt ||
                    (la_b_nxt != '0) || (hrep_nxt != 3'd0);

  // Pending replays and what stays after the current job; the held bytes
  // follow the first lookahead replay on the same index
  assign idx_inc = idx_r + 1'b1;
  assign h_end   = IDX_W'(la_a_r) + IDX_W'(hrep_r);
  assign h_idx   = idx_r[1:0] - la_a_r[1:0];
  assign pa      = idx_r   < IDX_W'(la_a_r);
  assign pb      = idx_r   < IDX_W'(la_b_r);
  assign ph      = idx_r   < h_end;
  assign pa_n    = idx_inc < IDX_W'(la_a_r);
  assign pb_n    = idx_inc < IDX_W'(la_b_r);
  assign ph_n    = idx_inc < h_end;

  // Next state
  always_comb begin
    fst_nxt = fst_r;
    unique case (fst_r)
      F_ACCEPT: if (accept && plan_any) fst_nxt = F_ISSUE;
      F_ISSUE:  if (q_push && !rest) fst_nxt = F_ACCEPT;
      default:  fst_nxt = F_ACCEPT;
    endcase
  end

  // Outputs: pick the next job in step order
  always_comb begin
    in_ready   = (fst_r == F_ACCEPT);
    q_push     = (fst_r == F_ISSUE) && !q_full;
    sel_pre    = 1'b0;
    sel_byte   = 1'b0;
    sel_famp   = 1'b0;
    sel_rep    = 1'b0;
    q_job.kind = K_RAW;
    q_job.data = '0;
    rest       = 1'b0;
    if (pre_v_r) begin
      sel_pre    = 1'b1;
      q_job.kind = pre_k_r;
      q_job.data = pre_d_r;
      rest       = pa || byte_v_r || famp_r || pb || ph;
    end else if (pa) begin
      sel_rep    = 1'b1;
      q_job.data = {13'd0, la_mem_r[idx_r[LA_IW-1:0]]};
      rest       = pa_n || byte_v_r || famp_r || pb || ph;
    end else if (byte_v_r) begin
      sel_byte   = 1'b1;
      q_job.kind = byte_k_r;
      q_job.data = {13'd0, byte_d_r};
      rest       = famp_r || pb || ph;
    end else if (famp_r) begin
      sel_famp   = 1'b1;
      q_job.kind = K_AMP;
      rest       = pb || ph;
    end else if (pb) begin
      sel_rep    = 1'b1;
      q_job.data = {13'd0, la_mem_r[idx_r[LA_IW-1:0]]};
      rest       = pb_n || ph;
    end else begin
      sel_rep    = 1'b1;
      q_job.data = {13'd0, hold_r[h_idx]};
      rest       = ph_n;
    end
    q_job.fin  = !rest;
    q_job.last = last_r && !rest;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r       <= F_ACCEPT;
      mode_r      <= M_IDLE;
      la_cnt_r    <= '0;
      hold_cnt_r  <= 3'd0;
      pass_left_r <= 2'd0;
      pre_v_r     <= 1'b0;
      byte_v_r    <= 1'b0;
      famp_r      <= 1'b0;
      la_a_r      <= '0;
      la_b_r      <= '0;
      hrep_r      <= 3'd0;
      idx_r       <= '0;
    end else begin
      fst_r <= fst_nxt;
      if (accept) begin
        mode_r      <= mode_nxt;
        la_cnt_r    <= la_cnt_nxt;
        hold_cnt_r  <= hold_cnt_nxt;
        pass_left_r <= pass_left_nxt;
        pre_v_r     <= pre_v_nxt;
        byte_v_r    <= byte_v_nxt;
        famp_r      <= famp_nxt;
        la_a_r      <= la_a_nxt;
        la_b_r      <= la_b_nxt;
        hrep_r      <= hrep_nxt;
        idx_r       <= '0;
      end else if (q_push) begin
        if (sel_pre)  pre_v_r  <= 1'b0;
        if (sel_byte) byte_v_r <= 1'b0;
        if (sel_famp) famp_r   <= 1'b0;
        if (sel_rep)  idx_r    <= idx_inc;
      end
    end
  end

  // Payload and buffers
  always_ff @(posedge clk) begin
    if (accept) begin
      pre_k_r  <= pre_k_nxt;
      pre_d_r  <= pre_d_nxt;
      byte_k_r <= byte_k_nxt;
      byte_d_r <= data_byte;
      last_r   <= last_of_string;
      if (la_we) la_mem_r[la_cnt_r[LA_IW-1:0]] <= data_byte;
      if (hold_we) hold_r[hold_wi] <= data_byte;
    end
  end

endmodule

// ===== rtl/core/xce_fifo.sv =====
// ----------------------------------------------------------------------------
// XML character escaper: job queue
// Short first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
module xce_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  xce_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output xce_pkg::job_t dout,
  output logic          empty
);
  import xce_pkg::*;

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_push, do_pop;

  assign full    = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{FIFO_AW{1'b0}}, do_push} - {{FIFO_AW{1'b0}}, do_pop};
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

endmodule

// ===== rtl/core/xce_back.sv =====
// ----------------------------------------------------------------------------
// XML character escaper: back
// Expands jobs into escaped text and drives the output register.
// ----------------------------------------------------------------------------
module xce_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  output logic          q_pop,
  input  xce_pkg::job_t q_job,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_byte,
  output logic          last_of_run,
  output logic          string_done
);
  import xce_pkg::*;

  bst_t            bst_r, bst_nxt;
  logic            fin_r, last_r;
  logic [20:0]     bin_r;
  logic [27:0]     bcd_r, bcd_adj;
  logic [4:0]      step_r;
  logic [9:0][7:0] buf_r;
  logic [3:0]      left_r;
  logic            out_v_r;
  logic [7:0]      out_byte_r;
  logic            out_lr_r, out_sd_r;
  logic            take, send_take, end_of_job;
  seq_t            fixed_seq, dec_seq;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = 8'h30 + {4'd0, nib};
    else c = 8'h37 + {4'd0, nib};
    return c;
  endfunction

  // Text for all pieces but the decimal reference
  function automatic seq_t build_fixed(input job_t j);
    seq_t       s;
    logic [7:0] b;
    s     = '0;
    b     = j.data[7:0];
    s.len = 4'd1;
    s.bytes[0] = b;
    case (j.kind)
      K_AMP: begin
        s.bytes[0] = "&"; s.bytes[1] = "a"; s.bytes[2] = "m";
        s.bytes[3] = "p"; s.bytes[4] = ";"; s.len = 4'd5;
      end
      K_LT: begin
        s.bytes[0] = "&"; s.bytes[1] = "l"; s.bytes[2] = "t";
        s.bytes[3] = ";"; s.len = 4'd4;
      end
      K_GT: begin
        s.bytes[0] = "&"; s.bytes[1] = "g"; s.bytes[2] = "t";
        s.bytes[3] = ";"; s.len = 4'd4;
      end
      K_QUOT: begin
        s.bytes[0] = "&"; s.bytes[1] = "q"; s.bytes[2] = "u";
        s.bytes[3] = "o"; s.bytes[4] = "t"; s.bytes[5] = ";"; s.len = 4'd6;
      end
      K_HEX: begin
        s.bytes[0] = "&"; s.bytes[1] = "#"; s.bytes[2] = "x";
        if (b[7:4] != 4'd0) begin
          s.bytes[3] = hex_char(b[7:4]);
          s.bytes[4] = hex_char(b[3:0]);
          s.bytes[5] = ";";
          s.len      = 4'd6;
        end else begin
          s.bytes[3] = hex_char(b[3:0]);
          s.bytes[4] = ";";
          s.len      = 4'd5;
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  // Decimal reference from BCD digits, leading zeros dropped
  function automatic seq_t build_dec(input logic [27:0] bcd);
    seq_t       s;
    logic [2:0] nd;
    logic [2:0] k;
    s = '0;
    if (bcd[27:24] != 4'd0) nd = 3'd7;
    else if (bcd[23:20] != 4'd0) nd = 3'd6;
    else nd = 3'd5;
    s.bytes[0] = "&";
    s.bytes[1] = "#";
    for (int i = 0; i < 7; i++) begin
      k = nd - 3'(i) - 3'd1;
      if (3'(i) < nd) s.bytes[2 + i] = {4'h3, bcd[4*k +: 4]};
    end
    s.bytes[{1'b0, nd} + 4'd2] = ";";
    s.len = {1'b0, nd} + 4'd3;
    return s;
  endfunction

  assign fixed_seq  = build_fixed(q_job);
  assign dec_seq    = build_dec(bcd_r);
  assign take       = !out_v_r || out_tready;
  assign send_take  = (bst_r == B_SEND) && take;
  assign end_of_job = (left_r == 4'd1);
  assign q_pop      = (bst_r == B_LOAD) && !q_empty;

  // Add three to each digit of five or more before the shift
  always_comb begin
    bcd_adj = bcd_r;
    for (int i = 0; i < 7; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
    end
  end

  // Next state
  always_comb begin
    bst_nxt = bst_r;
    unique case (bst_r)
      B_LOAD: if (!q_empty) bst_nxt = (q_job.kind == K_DEC) ? B_CONV : B_SEND;
      B_CONV: if (step_r == 5'd0) bst_nxt = B_SEND;
      B_SEND: if (take && end_of_job) bst_nxt = B_LOAD;
      default: bst_nxt = B_LOAD;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r   <= B_LOAD;
      out_v_r <= 1'b0;
    end else begin
      bst_r <= bst_nxt;
      if (send_take) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  // Load, convert and shift out
  always_ff @(posedge clk) begin
    if (q_pop) begin
      fin_r  <= q_job.fin;
      last_r <= q_job.last;
      bin_r  <= q_job.data;
      bcd_r  <= '0;
      step_r <= DEC_STEPS;
      buf_r  <= fixed_seq.bytes;
      left_r <= fixed_seq.len;
    end else if (bst_r == B_CONV) begin
      if (step_r != 5'd0) begin
        {bcd_r, bin_r} <= {bcd_adj[26:0], bin_r, 1'b0};
        step_r         <= step_r - 5'd1;
      end else begin
        buf_r  <= dec_seq.bytes;
        left_r <= dec_seq.len;
      end
    end else if (send_take) begin
      out_byte_r <= buf_r[0];
      out_lr_r   <= fin_r && end_of_job;
      out_sd_r   <= last_r && end_of_job;
      buf_r      <= buf_r >> 8;
      left_r     <= left_r - 4'd1;
    end
  end

  assign out_tvalid  = out_v_r;
  assign out_byte    = out_byte_r;
  assign last_of_run = out_lr_r;
  assign string_done = out_sd_r;

endmodule

// ===== rtl/core/xml_char_escape_encoder.sv =====
// ----------------------------------------------------------------------------
// XML character escaper: top level
// Escapes a UTF-8 byte stream for XML or HTML text and attribute output.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Payload
// in_       in   in_tvalid/in_tready     tdata=data_byte, tuser=in_attribute,
//                                        tlast=last_of_string
// out_      out  out_tvalid/out_tready   tdata=out_byte, tuser=string_done,
//                                        tlast=last_of_run
// cfg_      in   cfg_wen                 cfg_wdata=html_method
//
// A byte that makes no output is taken without issuing a job. Otherwise the
// front accepts no new byte until it has pushed every output piece of the
// last one, and the back loads a new piece only once it has sent every byte
// of the last; a decimal reference is first converted to BCD. Output
// bandwidth sets the sustained input rate. Reset is synchronous and clears
// all control state; the front and back stall on their own through a four-entry job queue.
// ----------------------------------------------------------------------------
module xml_char_escape_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [0:0] in_tuser,   // [0] in_attribute
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [0:0] out_tuser,  // [0] string_done
  output logic       out_tlast,
  input  logic       cfg_wen,
  input  logic [0:0] cfg_wdata
);
  import xce_pkg::*;

  logic html_r;
  logic q_push, q_full, q_pop, q_empty;
  job_t q_in, q_out;

  // Hold the output method register
  always_ff @(posedge clk) begin
    if (!rst_n) html_r <= 1'b0;
    else if (cfg_wen) html_r <= cfg_wdata[0];
  end

  xce_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .html_method    (html_r),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .data_byte      (in_tdata),
    .in_attribute   (in_tuser[0]),
    .last_of_string (in_tlast),
    .q_push         (q_push),
    .q_job          (q_in),
    .q_full         (q_full)
  );

  xce_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  xce_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_job       (q_out),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_byte    (out_tdata),
    .last_of_run (out_tlast),
    .string_done (out_tuser[0])
  );

endmodule

// ===== rtl/core/xce_checker.sv =====
// ----------------------------------------------------------------------------
// XML character escaper: port checker
// Watches the top level ports for input and output stream rules over time.
// ----------------------------------------------------------------------------
module xce_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [0:0] out_tuser,
  input logic       out_tlast
);

  // Stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("output changed while stalled");

  // String end only closes a run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("string end without run end");

  // Nothing shown straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Ready stays known after an input transaction
  a_in_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$isunknown(in_tready))
    else $error("input ready unknown");

endmodule

bind xml_char_escape_encoder xce_checker u_xce_checker (.*);
